// ===== src/tape_pulse_generator_defines.svh =====
// ----------------------------------------------------------------------------
// tape_pulse_generator_defines.svh
// assertion macros shared by the tape pulse generator rtl
// ----------------------------------------------------------------------------
`ifndef TAPE_PULSE_GENERATOR_DEFINES_SVH
`define TAPE_PULSE_GENERATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TPG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TPG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tpg_pkg.sv =====
// ----------------------------------------------------------------------------
// tpg_pkg
// types and constants of the tape pulse generator
// ----------------------------------------------------------------------------
`default_nettype none

package tpg_pkg;

    // byte store geometry
    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // stream widths
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // commands carried in tuser
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_TIMER = 2'd2,
        CMD_STOP  = 2'd3
    } t_cmd;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PILOT_COUNT  = 3'd0,
        REG_PAUSE_COUNT  = 3'd1,
        REG_PILOT_PERIOD = 3'd2,
        REG_SYNC_PERIOD  = 3'd3,
        REG_ZERO_PERIOD  = 3'd4,
        REG_ONE_PERIOD   = 3'd5,
        REG_GAP_PERIOD   = 3'd6,
        REG_PAUSE_PERIOD = 3'd7
    } t_cfg_reg;

    // configuration reset values
    localparam logic [15:0] RST_PILOT_COUNT  = 16'd4000;
    localparam logic [15:0] RST_PAUSE_COUNT  = 16'd4000;
    localparam logic [15:0] RST_PILOT_PERIOD = 16'd2168;
    localparam logic [15:0] RST_SYNC_PERIOD  = 16'd735;
    localparam logic [15:0] RST_ZERO_PERIOD  = 16'd855;
    localparam logic [15:0] RST_ONE_PERIOD   = 16'd1710;
    localparam logic [15:0] RST_GAP_PERIOD   = 16'd667;
    localparam logic [15:0] RST_PAUSE_PERIOD = 16'd1084;

    // bit position at the top of a byte
    localparam logic [3:0] BIT_TOP = 4'd7;

    // kind of the pulse being sent, one-hot
    typedef enum logic [5:0] {
        PK_PILOT = 6'b000001,
        PK_ONE   = 6'b000010,
        PK_ZERO  = 6'b000100,
        PK_SYNC  = 6'b001000,
        PK_END   = 6'b010000,
        PK_PAUSE = 6'b100000
    } t_pulse_kind;

endpackage

`default_nettype wire

// ===== src/tape_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// tape_pulse_generator
// plays one data block from a byte store as a cassette pulse sequence
// ----------------------------------------------------------------------------
// Each input transaction carries a command in tuser: write a byte into the
// store, start the block with a length, report a timer event, or stop. Every
// command returns exactly one result with the line level, the next timer
// period, the playing flag and the block_done flag. A command is handled as
// follows: on accept the store is read at the byte the next data pulse needs,
// and on commit the pulse state is updated from the registered byte and the
// result is loaded into the output register. The registered read of the
// 64K x 8 store sets these steps, so no new command is taken while one is
// still in flight. A result waiting at the output does not block a new
// command; only a command whose result cannot yet enter the full output
// register stays in flight. No clearing pass is needed after reset.
`default_nettype none
`include "tape_pulse_generator_defines.svh"

module tape_pulse_generator (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // command stream
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // addr [15:0], data [23:16], length [39:24]
    input  wire  [tpg_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // cmd [1:0]
    input  wire  [tpg_pkg::IN_USER_W-1:0]     i_s_axis_tuser,
    // result stream
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    // level [0], period [16:1], playing [17], block_done [18], zero [23:19]
    output logic [tpg_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // configuration writes
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [tpg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [tpg_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import tpg_pkg::*;

    // configuration registers
    logic [15:0] r_pilot_count, r_pause_count, r_pilot_period, r_sync_period;
    logic [15:0] r_zero_period, r_one_period, r_gap_period, r_pause_period;

    // playback state
    logic [15:0]  r_block_length, n_block_length;
    logic         r_half, n_half;
    t_pulse_kind  r_kind, n_kind;
    logic [15:0]  r_run, n_run;
    logic [15:0]  r_pos, n_pos;
    logic [3:0]   r_bit, n_bit;
    logic         r_active, n_active;
    logic [15:0]  r_period, n_period;
    logic         n_done;

    // transaction in flight
    logic         r_busy;
    t_cmd         r_cmd;
    logic [15:0]  r_addr;
    logic [7:0]   r_data;
    logic [15:0]  r_length;

    // byte store and its read register
    logic [7:0]        r_store [STORE_DEPTH];
    logic [7:0]        r_rd_data;
    logic [ADDR_W-1:0] rd_addr;

    // output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic        s_accept, commit, wr_en, byte_used;
    logic [15:0] pos_eff;
    logic [3:0]  bit_eff;
    logic        out_level;

    // handshakes
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_busy;
    assign commit          = r_busy && (!r_out_valid || i_m_axis_tready);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // byte the next data pulse uses, after stepping past a used-up byte
    assign byte_used = r_bit[3];
    assign pos_eff   = byte_used ? r_pos + 16'd1 : r_pos;
    assign bit_eff   = byte_used ? BIT_TOP : r_bit;
    assign rd_addr   = pos_eff[ADDR_W-1:0];

    // store write for a write command, addresses past the store dropped
    assign wr_en = commit && (r_cmd == CMD_WRITE)
                   && ({1'b0, r_addr} < 17'(STORE_DEPTH));

    // byte store: read on accept, write on commit
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_addr[ADDR_W-1:0]] <= r_data;
        end
        if (s_accept) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pilot_count  <= RST_PILOT_COUNT;
            r_pause_count  <= RST_PAUSE_COUNT;
            r_pilot_period <= RST_PILOT_PERIOD;
            r_sync_period  <= RST_SYNC_PERIOD;
            r_zero_period  <= RST_ZERO_PERIOD;
            r_one_period   <= RST_ONE_PERIOD;
            r_gap_period   <= RST_GAP_PERIOD;
            r_pause_period <= RST_PAUSE_PERIOD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_PILOT_COUNT:  r_pilot_count  <= i_cfg_data;
                REG_PAUSE_COUNT:  r_pause_count  <= i_cfg_data;
                REG_PILOT_PERIOD: r_pilot_period <= i_cfg_data;
                REG_SYNC_PERIOD:  r_sync_period  <= i_cfg_data;
                REG_ZERO_PERIOD:  r_zero_period  <= i_cfg_data;
                REG_ONE_PERIOD:   r_one_period   <= i_cfg_data;
                REG_GAP_PERIOD:   r_gap_period   <= i_cfg_data;
                REG_PAUSE_PERIOD: r_pause_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // capture the accepted command
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd    <= t_cmd'(i_s_axis_tuser);
            r_addr   <= i_s_axis_tdata[15:0];
            r_data   <= i_s_axis_tdata[23:16];
            r_length <= i_s_axis_tdata[39:24];
        end
    end

    // next pulse and state update
    always_comb begin
        logic next_req;
        logic bit_val;
        n_block_length = r_block_length;
        n_half         = r_half;
        n_kind         = r_kind;
        n_run          = r_run;
        n_pos          = r_pos;
        n_bit          = r_bit;
        n_active       = r_active;
        n_period       = r_period;
        n_done         = 1'b0;
        next_req       = 1'b0;
        bit_val        = r_rd_data[bit_eff[2:0]];

        case (r_cmd)
            CMD_START: begin
                n_block_length = r_length;
                n_run          = r_pilot_count;
                n_pos          = '0;
                n_kind         = PK_PILOT;
                n_active       = 1'b1;
                next_req       = 1'b1;
            end
            CMD_TIMER: begin
                if (r_active) begin
                    if (!r_half) begin
                        n_half = 1'b1;
                    end else begin
                        next_req = 1'b1;
                    end
                end
            end
            CMD_STOP: begin
                n_active = 1'b0;
                n_half   = 1'b0;
                n_period = '0;
            end
            default: ;
        endcase

        // pulse sequencing; start always enters the pilot branch
        if (next_req) begin
            n_half = 1'b0;
            if (r_cmd == CMD_START || r_kind == PK_PILOT) begin
                if (n_run != 16'd0) begin
                    n_run    = n_run - 16'd1;
                    n_period = r_pilot_period;
                end else begin
                    n_kind   = PK_SYNC;
                    n_bit    = BIT_TOP;
                    n_period = r_sync_period;
                end
            end else begin
                case (r_kind)
                    PK_END: begin
                        n_kind   = PK_PAUSE;
                        n_run    = r_pause_count;
                        n_period = r_gap_period;
                    end
                    PK_PAUSE: begin
                        if (r_run != 16'd0) begin
                            n_run    = r_run - 16'd1;
                            n_period = r_pause_period;
                        end else begin
                            n_active = 1'b0;
                            n_period = '0;
                            n_done   = 1'b1;
                        end
                    end
                    default: begin
                        n_pos = pos_eff;
                        n_bit = bit_eff;
                        if (pos_eff >= r_block_length) begin
                            n_kind   = PK_END;
                            n_period = r_one_period;
                        end else begin
                            n_bit = bit_eff - 4'd1;
                            if (bit_val) begin
                                n_kind   = PK_ONE;
                                n_period = r_one_period;
                            end else begin
                                n_kind   = PK_ZERO;
                                n_period = r_zero_period;
                            end
                        end
                    end
                endcase
            end
        end
    end

    assign out_level = n_active && !n_half && (n_kind != PK_PAUSE);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_out_valid    <= 1'b0;
            r_block_length <= '0;
            r_half         <= 1'b0;
            r_kind         <= PK_PILOT;
            r_run          <= '0;
            r_pos          <= '0;
            r_bit          <= BIT_TOP;
            r_active       <= 1'b0;
            r_period       <= '0;
        end else begin
            if (s_accept) begin
                r_busy <= 1'b1;
            end else if (commit) begin
                r_busy <= 1'b0;
            end
            if (commit) begin
                r_out_valid    <= 1'b1;
                r_block_length <= n_block_length;
                r_half         <= n_half;
                r_kind         <= n_kind;
                r_run          <= n_run;
                r_pos          <= n_pos;
                r_bit          <= n_bit;
                r_active       <= n_active;
                r_period       <= n_period;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_data <= {5'd0, n_done, n_active,
                           (n_active ? n_period : 16'd0), out_level};
        end
    end

    // checks
    `TPG_ASSERT_NXT(a_accept_busy, s_accept, r_busy && !o_s_axis_tready,
        "accepted command not held in flight")
    `TPG_ASSERT_NXT(a_stall_holds, r_busy && r_out_valid && !i_m_axis_tready,
        r_busy, "stalled command left without a result")
    `TPG_ASSERT_NXT(a_done_stops, commit && n_done, !r_active,
        "block_done given while still playing")
    `TPG_ASSERT_IMP(a_idle_low_half, !r_active, !r_half,
        "half phase set while idle")

endmodule

`default_nettype wire

// ===== tb/tape_pulse_generator_tb.sv =====
// ----------------------------------------------------------------------------
// tape_pulse_generator_tb
// self-checking testbench of the tape pulse generator
// ----------------------------------------------------------------------------
// Drives write, start, timer and stop commands into the command stream. A
// local copy of the pulse sequencer predicts one result per command, and each
// result transaction is checked against the oldest prediction. Directed tests
// cover the reset settings, a zero-length block with zero counts, and the
// register and field extremes. Random block traffic then runs under three
// handshake idling mixes with a new register setting for each. Store bytes
// are always written before the sequencer can read them.

module tape_pulse_generator_tb;

    import tpg_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    // one predicted result transaction
    typedef struct packed {
        logic        level;
        logic [15:0] period;
        logic        playing;
        logic        block_done;
    } t_tape_result;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // command stream
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [IN_USER_W-1:0]  s_tuser  = '0;

    // result stream
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // configuration channel
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // handshake idling, percent of cycles
    int src_idle_pct = 0;
    int snk_idle_pct = 0;

    int cycle_count    = 0;
    int mismatch_count = 0;
    int sent_count     = 0;

    t_tape_result pending_results[$];

    // shadow of the block state
    logic [15:0]  cfg_shadow [8];
    logic [7:0]   tape_bytes [0:STORE_DEPTH-1];
    bit           byte_written [0:STORE_DEPTH-1];
    logic [15:0]  blk_len    = '0;
    logic         half_q     = 1'b0;
    t_pulse_kind  kind_q     = PK_PILOT;
    logic [15:0]  run_left   = '0;
    logic [15:0]  byte_pos   = '0;
    logic [3:0]   bit_pos    = BIT_TOP;
    logic         playing_q  = 1'b0;
    logic [15:0]  period_q   = '0;

    tape_pulse_generator u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // clock, period 20
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // move to the next pulse; returns 1 when the block has just ended
    function automatic logic advance_pulse();
        logic [7:0] cur_byte;
        logic       cur_bit;
        half_q = 1'b0;
        case (kind_q)
            PK_PILOT: begin
                if (run_left != 16'd0) begin
                    run_left = run_left - 16'd1;
                    period_q = cfg_shadow[REG_PILOT_PERIOD];
                end else begin
                    kind_q   = PK_SYNC;
                    bit_pos  = BIT_TOP;
                    period_q = cfg_shadow[REG_SYNC_PERIOD];
                end
                return 1'b0;
            end
            PK_END: begin
                kind_q   = PK_PAUSE;
                run_left = cfg_shadow[REG_PAUSE_COUNT];
                period_q = cfg_shadow[REG_GAP_PERIOD];
                return 1'b0;
            end
            PK_PAUSE: begin
                if (run_left != 16'd0) begin
                    run_left = run_left - 16'd1;
                    period_q = cfg_shadow[REG_PAUSE_PERIOD];
                    return 1'b0;
                end
                playing_q = 1'b0;
                period_q  = 16'd0;
                return 1'b1;
            end
            default: ;
        endcase
        // data pulses, sync leads into the first bit
        if (bit_pos >= 4'd8) begin
            bit_pos  = BIT_TOP;
            byte_pos = byte_pos + 16'd1;
        end
        if (byte_pos >= blk_len) begin
            kind_q   = PK_END;
            period_q = cfg_shadow[REG_ONE_PERIOD];
            return 1'b0;
        end
        cur_byte = tape_bytes[byte_pos];
        cur_bit  = cur_byte[bit_pos[2:0]];
        bit_pos  = bit_pos - 4'd1;
        kind_q   = cur_bit ? PK_ONE : PK_ZERO;
        period_q = cur_bit ? cfg_shadow[REG_ONE_PERIOD] : cfg_shadow[REG_ZERO_PERIOD];
        return 1'b0;
    endfunction

    // apply one command to the shadow state and build its result
    function automatic t_tape_result predict_tape(input t_cmd cmd, input logic [15:0] addr,
                                                  input logic [7:0] data,
                                                  input logic [15:0] length);
        t_tape_result res;
        logic         done;
        done = 1'b0;
        case (cmd)
            CMD_WRITE: begin
                tape_bytes[addr]   = data;
                byte_written[addr] = 1'b1;
            end
            CMD_START: begin
                blk_len   = length;
                run_left  = cfg_shadow[REG_PILOT_COUNT];
                byte_pos  = 16'd0;
                kind_q    = PK_PILOT;
                playing_q = 1'b1;
                done      = advance_pulse();
            end
            CMD_TIMER: begin
                // ignored while idle
                if (playing_q) begin
                    if (!half_q) half_q = 1'b1;
                    else         done = advance_pulse();
                end
            end
            default: begin
                playing_q = 1'b0;
                half_q    = 1'b0;
                period_q  = 16'd0;
            end
        endcase
        res.level      = playing_q && !half_q && (kind_q != PK_PAUSE);
        res.period     = playing_q ? period_q : 16'd0;
        res.playing    = playing_q;
        res.block_done = done;
        return res;
    endfunction

    // send one command transaction, with random idle cycles ahead of it
    task automatic send_tape_cmd(input t_cmd cmd, input logic [15:0] addr,
                                 input logic [7:0] data, input logic [15:0] length);
        pending_results.push_back(predict_tape(cmd, addr, data, length));
        sent_count++;
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {length, data, addr};
        s_tuser  <= cmd;
        do @(posedge clk); while (!s_tready);
    endtask

    // write a store byte with random content if it was never written
    task automatic ensure_byte(input logic [15:0] addr);
        if (!byte_written[addr])
            send_tape_cmd(CMD_WRITE, addr, 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)));
    endtask

    // send a command, first filling any byte the sequencer may read next
    task automatic issue_cmd(input t_cmd cmd, input logic [15:0] addr,
                             input logic [7:0] data, input logic [15:0] length);
        if (cmd == CMD_START) begin
            ensure_byte(16'd0);
            ensure_byte(16'd1);
        end else if (cmd != CMD_WRITE) begin
            ensure_byte(byte_pos);
            ensure_byte(byte_pos + 16'd1);
        end
        send_tape_cmd(cmd, addr, data, length);
    endtask

    task automatic timer_event();
        issue_cmd(CMD_TIMER, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 65535)));
    endtask

    task automatic stop_event();
        issue_cmd(CMD_STOP, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 65535)));
    endtask

    // one configuration write transaction
    task automatic write_reg(input t_cfg_reg idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_shadow[idx] = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // release the command stream and wait for every result
    task automatic settle_block();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // preload the first bytes of a block, then start it
    task automatic start_block();
        logic [15:0] len;
        int          pick;
        int          preload;
        pick = $urandom_range(0, 99);
        if (pick < 70)      len = 16'($urandom_range(1, 6));
        else if (pick < 85) len = 16'($urandom_range(7, 24));
        else                len = 16'($urandom_range(0, 65535));
        preload = (len < 16'd8) ? int'(len) : 8;
        for (int i = 0; i < preload; i++)
            send_tape_cmd(CMD_WRITE, 16'(i), 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)));
        issue_cmd(CMD_START, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), len);
    endtask

    // small counts keep blocks short, periods span 1 to 65535
    task automatic load_random_setting();
        write_reg(REG_PILOT_COUNT, 16'($urandom_range(0, 3)));
        write_reg(REG_PAUSE_COUNT, 16'($urandom_range(0, 3)));
        write_reg(REG_PILOT_PERIOD, 16'($urandom_range(1, 65535)));
        write_reg(REG_SYNC_PERIOD, 16'($urandom_range(1, 65535)));
        write_reg(REG_ZERO_PERIOD, 16'($urandom_range(1, 65535)));
        write_reg(REG_ONE_PERIOD, 16'($urandom_range(1, 65535)));
        write_reg(REG_GAP_PERIOD, 16'($urandom_range(1, 65535)));
        write_reg(REG_PAUSE_PERIOD, 16'($urandom_range(1, 65535)));
    endtask

    // reset register values, timer while idle, start and stop
    task automatic check_reset_values();
        issue_cmd(CMD_WRITE, 16'h0000, 8'h00, 16'h0000);
        issue_cmd(CMD_WRITE, 16'h0001, 8'hFF, 16'hFFFF);
        timer_event();
        issue_cmd(CMD_START, 16'h0000, 8'h00, 16'd1);
        timer_event();
        timer_event();
        stop_event();
        settle_block();
    endtask

    // zero-length block with no pilot and no pause, played to block_done
    task automatic check_short_block();
        write_reg(REG_PILOT_COUNT, 16'd0);
        write_reg(REG_PAUSE_COUNT, 16'd0);
        write_reg(REG_PILOT_PERIOD, 16'd1);
        write_reg(REG_SYNC_PERIOD, 16'hFFFF);
        write_reg(REG_ZERO_PERIOD, 16'd1);
        write_reg(REG_ONE_PERIOD, 16'hFFFF);
        write_reg(REG_GAP_PERIOD, 16'hFFFF);
        write_reg(REG_PAUSE_PERIOD, 16'd1);
        issue_cmd(CMD_START, 16'hFFFF, 8'hFF, 16'd0);
        repeat (6) timer_event();
        timer_event();
        settle_block();
    endtask

    // full counts, zero periods, top address, longest length, restart
    task automatic check_extremes();
        write_reg(REG_PILOT_COUNT, 16'hFFFF);
        write_reg(REG_PAUSE_COUNT, 16'hFFFF);
        write_reg(REG_PILOT_PERIOD, 16'd0);
        write_reg(REG_SYNC_PERIOD, 16'd0);
        write_reg(REG_ZERO_PERIOD, 16'd0);
        write_reg(REG_ONE_PERIOD, 16'd0);
        write_reg(REG_GAP_PERIOD, 16'd0);
        write_reg(REG_PAUSE_PERIOD, 16'd0);
        issue_cmd(CMD_START, 16'h0000, 8'h00, 16'hFFFF);
        timer_event();
        issue_cmd(CMD_WRITE, 16'hFFFF, 8'hFF, 16'h0000);
        issue_cmd(CMD_WRITE, 16'hFFFF, 8'h00, 16'hFFFF);
        issue_cmd(CMD_START, 16'hFFFF, 8'hFF, 16'd1);
        timer_event();
        stop_event();
        settle_block();
    endtask

    // mostly well-formed blocks, with writes, restarts and stops mixed in
    task automatic run_tape_traffic(input int n_items);
        int target;
        int pick;
        target = sent_count + n_items;
        while (sent_count < target) begin
            pick = $urandom_range(0, 99);
            if (!playing_q) begin
                if (pick < 60)      start_block();
                else if (pick < 80) issue_cmd(CMD_WRITE, 16'($urandom_range(0, 65535)),
                                              8'($urandom_range(0, 255)),
                                              16'($urandom_range(0, 65535)));
                else if (pick < 95) timer_event();
                else                stop_event();
            end else begin
                if (pick < 86)      timer_event();
                // rewrite bytes that are about to be sent
                else if (pick < 92) issue_cmd(CMD_WRITE,
                                              16'(byte_pos + $urandom_range(0, 3)),
                                              8'($urandom_range(0, 255)),
                                              16'($urandom_range(0, 65535)));
                else if (pick < 95) issue_cmd(CMD_WRITE, 16'($urandom_range(0, 65535)),
                                              8'($urandom_range(0, 255)),
                                              16'($urandom_range(0, 65535)));
                else if (pick < 98) start_block();
                else                stop_event();
            end
        end
        if (playing_q) stop_event();
        settle_block();
    endtask

    // receiver ready, changed at the falling edge
    always @(negedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // check each result transaction against the oldest prediction
    always @(posedge clk) begin : result_check
        t_tape_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with none expected: tdata %h", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.level) begin
                    $error("level: expected %0d, got %0d", want.level, m_tdata[0]);
                    mismatch_count++;
                end
                if (m_tdata[16:1] !== want.period) begin
                    $error("period: expected %0d, got %0d", want.period, m_tdata[16:1]);
                    mismatch_count++;
                end
                if (m_tdata[17] !== want.playing) begin
                    $error("playing: expected %0d, got %0d", want.playing, m_tdata[17]);
                    mismatch_count++;
                end
                if (m_tdata[18] !== want.block_done) begin
                    $error("block_done: expected %0d, got %0d", want.block_done, m_tdata[18]);
                    mismatch_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // test sequence
    initial begin
        cfg_shadow[REG_PILOT_COUNT]  = RST_PILOT_COUNT;
        cfg_shadow[REG_PAUSE_COUNT]  = RST_PAUSE_COUNT;
        cfg_shadow[REG_PILOT_PERIOD] = RST_PILOT_PERIOD;
        cfg_shadow[REG_SYNC_PERIOD]  = RST_SYNC_PERIOD;
        cfg_shadow[REG_ZERO_PERIOD]  = RST_ZERO_PERIOD;
        cfg_shadow[REG_ONE_PERIOD]   = RST_ONE_PERIOD;
        cfg_shadow[REG_GAP_PERIOD]   = RST_GAP_PERIOD;
        cfg_shadow[REG_PAUSE_PERIOD] = RST_PAUSE_PERIOD;
        src_idle_pct = 18;
        snk_idle_pct = 80;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        check_reset_values();
        check_short_block();
        check_extremes();

        load_random_setting();
        run_tape_traffic(350);

        src_idle_pct = 80;
        snk_idle_pct = 18;
        load_random_setting();
        run_tape_traffic(350);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        load_random_setting();
        run_tape_traffic(350);

        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/tpg_pkg.sv
src/tape_pulse_generator.sv
tb/tape_pulse_generator_tb.sv
